>>> sv/sdiv_pkg.sv
// Shared types and constants for the signed restoring divider.
package sdiv_pkg;

  // Default operand width.
  localparam int SDIV_DATA_WIDTH = 32;

  // Control that travels with each beat down the pipeline.
  typedef struct packed {
    logic valid;   // stage holds a live beat
    logic neg;     // quotient must be negated at the end
    logic dbz;     // divisor was zero
  } sdiv_ctl_t;

endpackage

>>> sv/signed_restoring_divider.sv
// Signed restoring divider: fully pipelined, one step per stage.
// Path from start to done, every stage registered:
//   one input stage, DATA_WIDTH shift-subtract stages, one output stage.
// Throughput: one beat per cycle; busy is always low, results cannot stall.
// Reset (rst, synchronous) clears every stage valid bit; data is not reset.
module signed_restoring_divider import sdiv_pkg::*; #(
  parameter int DATA_WIDTH = SDIV_DATA_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [DATA_WIDTH-1:0] dividend,
  input  logic [DATA_WIDTH-1:0] divisor,
  output logic                  done,
  output logic [DATA_WIDTH-1:0] quotient,
  output logic                  div_by_zero
);

  sdiv_ctl_t             ctl_pipe [0:DATA_WIDTH];
  logic [DATA_WIDTH-1:0] rem_pipe [0:DATA_WIDTH];
  logic [DATA_WIDTH-1:0] nq_pipe  [0:DATA_WIDTH];
  logic [DATA_WIDTH-1:0] den_pipe [0:DATA_WIDTH];

  // Pipeline never stalls, so a beat is taken whenever start is high.
  assign busy = 1'b0;

  sdiv_prep #(.DATA_WIDTH(DATA_WIDTH)) u_prep (
    .clk      (clk),
    .rst      (rst),
    .accept   (start && !busy),
    .dividend (dividend),
    .divisor  (divisor),
    .ctl      (ctl_pipe[0]),
    .rem      (rem_pipe[0]),
    .nq       (nq_pipe[0]),
    .den      (den_pipe[0])
  );

  // One restoring step per stage, most significant quotient bit first.
  for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_step
    sdiv_step #(.DATA_WIDTH(DATA_WIDTH)) u_step (
      .clk    (clk),
      .rst    (rst),
      .ctl_in (ctl_pipe[i]),
      .rem_in (rem_pipe[i]),
      .nq_in  (nq_pipe[i]),
      .den_in (den_pipe[i]),
      .ctl    (ctl_pipe[i+1]),
      .rem    (rem_pipe[i+1]),
      .nq     (nq_pipe[i+1]),
      .den    (den_pipe[i+1])
    );
  end

  sdiv_post #(.DATA_WIDTH(DATA_WIDTH)) u_post (
    .clk         (clk),
    .rst         (rst),
    .ctl_in      (ctl_pipe[DATA_WIDTH]),
    .mag_in      (nq_pipe[DATA_WIDTH]),
    .done        (done),
    .quotient    (quotient),
    .div_by_zero (div_by_zero)
  );

endmodule

>>> sv/sdiv_prep.sv
// Input stage: takes operand magnitudes and the result sign.
module sdiv_prep import sdiv_pkg::*; #(
  parameter int DATA_WIDTH = SDIV_DATA_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  logic [DATA_WIDTH-1:0] dividend,
  input  logic [DATA_WIDTH-1:0] divisor,
  output sdiv_ctl_t             ctl,
  output logic [DATA_WIDTH-1:0] rem,
  output logic [DATA_WIDTH-1:0] nq,
  output logic [DATA_WIDTH-1:0] den
);

  logic [DATA_WIDTH-1:0] num_mag_next;
  logic [DATA_WIDTH-1:0] den_mag_next;
  sdiv_ctl_t             ctl_next;

  // Two's complement magnitude; the most negative value maps to 2^(W-1).
  always_comb begin
    num_mag_next = dividend[DATA_WIDTH-1] ? (~dividend + 1'b1) : dividend;
    den_mag_next = divisor[DATA_WIDTH-1]  ? (~divisor + 1'b1)  : divisor;
    ctl_next.valid = accept;
    ctl_next.neg   = dividend[DATA_WIDTH-1] ^ divisor[DATA_WIDTH-1];
    ctl_next.dbz   = (divisor == '0);
  end

  // Stage registers; only the valid bit needs reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.valid <= 1'b0;
    end else begin
      ctl <= ctl_next;
    end
    rem <= '0;
    nq  <= num_mag_next;
    den <= den_mag_next;
  end

endmodule

>>> sv/sdiv_step.sv
// One restoring shift-and-subtract step, registered.
module sdiv_step import sdiv_pkg::*; #(
  parameter int DATA_WIDTH = SDIV_DATA_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  sdiv_ctl_t             ctl_in,
  input  logic [DATA_WIDTH-1:0] rem_in,
  input  logic [DATA_WIDTH-1:0] nq_in,
  input  logic [DATA_WIDTH-1:0] den_in,
  output sdiv_ctl_t             ctl,
  output logic [DATA_WIDTH-1:0] rem,
  output logic [DATA_WIDTH-1:0] nq,
  output logic [DATA_WIDTH-1:0] den
);

  logic [DATA_WIDTH:0]   shifted;
  logic [DATA_WIDTH:0]   diff;
  logic                  fits;
  logic [DATA_WIDTH-1:0] rem_next;
  logic [DATA_WIDTH-1:0] nq_next;

  // Shift in the next dividend bit, subtract when the divisor fits.
  // nq holds unused dividend bits on top and quotient bits below.
  always_comb begin
    shifted  = {rem_in, nq_in[DATA_WIDTH-1]};
    diff     = shifted - {1'b0, den_in};
    fits     = (shifted >= {1'b0, den_in});
    rem_next = fits ? diff[DATA_WIDTH-1:0] : shifted[DATA_WIDTH-1:0];
    nq_next  = {nq_in[DATA_WIDTH-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.valid <= 1'b0;
    end else begin
      ctl <= ctl_in;
    end
    rem <= rem_next;
    nq  <= nq_next;
    den <= den_in;
  end

endmodule

>>> sv/sdiv_post.sv
// Output stage: applies the sign and the zero-divisor result.
module sdiv_post import sdiv_pkg::*; #(
  parameter int DATA_WIDTH = SDIV_DATA_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  sdiv_ctl_t             ctl_in,
  input  logic [DATA_WIDTH-1:0] mag_in,
  output logic                  done,
  output logic [DATA_WIDTH-1:0] quotient,
  output logic                  div_by_zero
);

  logic [DATA_WIDTH-1:0] quo_next;

  // Zero divisor gives all ones; otherwise negate when signs differ.
  always_comb begin
    if (ctl_in.dbz) begin
      quo_next = '1;
    end else if (ctl_in.neg) begin
      quo_next = ~mag_in + 1'b1;
    end else begin
      quo_next = mag_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl_in.valid;
    end
    quotient    <= quo_next;
    div_by_zero <= ctl_in.dbz;
  end

endmodule

>>> bench/signed_restoring_divider_test.sv
// Self-checking testbench for the pipelined signed restoring divider.
module signed_restoring_divider_test;
  import sdiv_pkg::*;

  localparam int W = SDIV_DATA_WIDTH;
  localparam int LATENCY = W + 2;
  localparam logic [W-1:0] MOST_NEG = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] MOST_POS = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MINUS_ONE = '1;

  typedef struct packed {
    logic [W-1:0] dividend;
    logic [W-1:0] divisor;
  } division_t;

  typedef struct packed {
    logic [W-1:0] quotient;
    logic         div_by_zero;
  } quotient_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [W-1:0] dividend = '0;
  logic [W-1:0] divisor = '0;
  logic busy;
  logic done;
  logic [W-1:0] quotient;
  logic div_by_zero;

  division_t pending_divisions[$];
  quotient_t expected_quotients[$];
  quotient_t want;
  int idle_pct = 0;
  int mismatches = 0;

  signed_restoring_divider #(.DATA_WIDTH(W)) u_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .dividend   (dividend),
    .divisor    (divisor),
    .done       (done),
    .quotient   (quotient),
    .div_by_zero(div_by_zero)
  );

  always #10 clk = ~clk;

  // Truncating signed division: divide magnitudes bit by bit, then fix the sign.
  function automatic quotient_t predict_division(division_t op);
    quotient_t    res;
    logic [W-1:0] num;
    logic [W-1:0] den;
    logic [W-1:0] rem;
    logic [W-1:0] quo;
    logic [W:0]   trial;
    logic         neg;
    res.div_by_zero = 1'b0;
    if (op.divisor == '0) begin
      res.quotient    = MINUS_ONE;
      res.div_by_zero = 1'b1;
      return res;
    end
    neg = op.dividend[W-1] ^ op.divisor[W-1];
    // -MOST_NEG wraps to itself, which is the right unsigned magnitude
    num = op.dividend[W-1] ? -op.dividend : op.dividend;
    den = op.divisor[W-1] ? -op.divisor : op.divisor;
    rem = '0;
    quo = '0;
    for (int i = W - 1; i >= 0; i--) begin
      trial = {rem, num[i]};
      quo = quo << 1;
      if (trial >= {1'b0, den}) begin
        trial = trial - {1'b0, den};
        quo[0] = 1'b1;
      end
      rem = trial[W-1:0];
    end
    res.quotient = neg ? -quo : quo;
    return res;
  endfunction

  task automatic note_failure(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endtask

  task automatic add_division(logic [W-1:0] a, logic [W-1:0] b);
    pending_divisions.push_back('{dividend: a, divisor: b});
  endtask

  // Operand mix: full-range values plus the corners that exercise sign and size
  function automatic logic [W-1:0] random_operand();
    logic [63:0]  wide;
    logic [W-1:0] v;
    wide = {$urandom, $urandom};
    case ($urandom_range(7))
      0: v = $urandom_range(15);
      1: begin
        case ($urandom_range(4))
          0: v = '0;
          1: v = 1;
          2: v = MINUS_ONE;
          3: v = MOST_NEG;
          default: v = MOST_POS;
        endcase
        return v;
      end
      2: v = {{(W-1){1'b0}}, 1'b1} << $urandom_range(W - 1);
      3: v = wide[W-1:0] & (MINUS_ONE >> $urandom_range(W - 1));
      default: return wide[W-1:0];
    endcase
    if ($urandom_range(1)) v = -v;
    return v;
  endfunction

  task automatic add_random_division();
    logic [W-1:0] a;
    logic [W-1:0] b;
    a = random_operand();
    case ($urandom_range(9))
      0: b = a;
      1: b = -a;
      2: b = a >>> $urandom_range(W - 1);
      3: b = a + $urandom_range(3) - 1;
      default: b = random_operand();
    endcase
    add_division(a, b);
  endtask

  task automatic wait_drained();
    while (pending_divisions.size() != 0 || start || expected_quotients.size() != 0)
      @(negedge clk);
  endtask

  // Driver: one beat per accepted start; idle cycles drive junk operands
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy)
        expected_quotients.push_back(predict_division('{dividend: dividend, divisor: divisor}));
      if (!start || !busy) begin
        if (pending_divisions.size() != 0 && $urandom_range(99) >= idle_pct) begin
          dividend <= pending_divisions[0].dividend;
          divisor  <= pending_divisions[0].divisor;
          void'(pending_divisions.pop_front());
          start    <= 1'b1;
        end else begin
          dividend <= $urandom;
          divisor  <= $urandom;
          start    <= 1'b0;
        end
      end
    end
  end

  // Monitor: every done beat must match the oldest outstanding prediction
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_quotients.size() == 0) begin
        note_failure($sformatf("unexpected result: quotient=%h div_by_zero=%b",
                               quotient, div_by_zero));
      end else begin
        want = expected_quotients.pop_front();
        if (quotient !== want.quotient)
          note_failure($sformatf("quotient mismatch: expected %h, got %h",
                                 want.quotient, quotient));
        if (div_by_zero !== want.div_by_zero)
          note_failure($sformatf("div_by_zero mismatch: expected %b, got %b",
                                 want.div_by_zero, div_by_zero));
      end
    end
  end

  initial begin
    int phase_idle[5];
    phase_idle = '{0, 51, 33, 0, 51};
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed corners: signs, extremes, zero divisor, overflow wrap
    add_division(0, 1);
    add_division(0, 0);
    add_division(5, 0);
    add_division(-5, 0);
    add_division(MOST_NEG, 0);
    add_division(MOST_NEG, MINUS_ONE);
    add_division(MOST_NEG, 1);
    add_division(MOST_NEG, MOST_NEG);
    add_division(MOST_NEG, 2);
    add_division(MOST_POS, 1);
    add_division(MOST_POS, MINUS_ONE);
    add_division(MOST_POS, MOST_POS);
    add_division(MOST_POS, MOST_NEG);
    add_division(1, MOST_NEG);
    add_division(MINUS_ONE, MOST_POS);
    add_division(MINUS_ONE, MINUS_ONE);
    add_division(7, 2);
    add_division(-7, 2);
    add_division(7, -2);
    add_division(-7, -2);
    add_division(3, 5);
    add_division(-3, 5);
    add_division(123456789, 1000);
    add_division(MINUS_ONE, 0);
    wait_drained();

    // Random phases with different sender idle rates
    foreach (phase_idle[p]) begin
      idle_pct = phase_idle[p];
      repeat (200) add_random_division();
      wait_drained();
    end
    idle_pct = 0;

    repeat (LATENCY + 8) @(negedge clk);
    if (expected_quotients.size() != 0)
      note_failure($sformatf("%0d results never arrived", expected_quotients.size()));
    if (mismatches == 0) begin
      $display("signed_restoring_divider regression: pass");
    end else begin
      $display("signed_restoring_divider regression: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4000000;
    $display("signed_restoring_divider regression: fail");
    $finish;
  end

endmodule
